>>> rtl/core/quaternion_vector_rotation_assert.svh
// Assertion macros for the quaternion vector rotation core.
`ifndef QUATERNION_VECTOR_ROTATION_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATION_ASSERT_SVH
`ifndef SYNTH
`define QVR_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define QVR_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define QVR_ASSERT_IMP(label, clk, rst, a, b)
`define QVR_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> rtl/core/qvr_pkg.sv
// Package: shared constants for the quaternion vector rotation core.
`timescale 1ns / 1ps
package qvr_pkg;
  localparam int unsigned CompWidth = 16;
  localparam int unsigned OutWidth  = CompWidth + 2;
  // Squared norm, t = q*(0,v) and numerator widths.
  localparam int unsigned NormWidth = 2 * CompWidth + 2;
  localparam int unsigned TWidth    = 2 * CompWidth + 2;
  localparam int unsigned NumWidth  = TWidth + CompWidth + 3;
  // Quotient bits worth computing: beyond this the result saturates anyway.
  localparam int unsigned QuoBits   = OutWidth + 1;
  localparam int unsigned InBytes   = (7 * CompWidth + 7) / 8;
  localparam int unsigned OutBytes  = (3 * OutWidth + 7) / 8;
endpackage

>>> rtl/core/qvr_mul.sv
// Hamilton products: squared norm, q*p, and the vector part of t*conj(q).
`timescale 1ns / 1ps
module qvr_mul (
  input  logic clk,
  input  logic en,
  input  logic signed [qvr_pkg::CompWidth-1:0] qw, qx, qy, qz, vx, vy, vz,
  output logic signed [qvr_pkg::NormWidth-1:0] norm,
  output logic signed [qvr_pkg::NumWidth-1:0]  nx, ny, nz
);
  localparam int unsigned CW = qvr_pkg::CompWidth;
  localparam int unsigned TW = qvr_pkg::TWidth;
  localparam int unsigned NW = qvr_pkg::NumWidth;

  logic signed [2*CW-1:0] p_ww, p_xx, p_yy, p_zz;
  logic signed [2*CW-1:0] p_xvx, p_yvy, p_zvz, p_wvx, p_yvz, p_zvy;
  logic signed [2*CW-1:0] p_wvy, p_xvz, p_zvx, p_wvz, p_xvy, p_yvx;
  logic signed [CW-1:0]   s1_w, s1_x, s1_y, s1_z;
  logic signed [TW-1:0]   tw, tx, ty, tz;
  logic signed [CW-1:0]   s2_w, s2_x, s2_y, s2_z;
  logic signed [NW-1:0]   m [12];
  logic signed [qvr_pkg::NormWidth-1:0] n1, n2;

  // Stage 1: sixteen component products.
  always_ff @(posedge clk) begin
    if (en) begin
      p_ww <= qw * qw; p_xx <= qx * qx; p_yy <= qy * qy; p_zz <= qz * qz;
      p_xvx <= qx * vx; p_yvy <= qy * vy; p_zvz <= qz * vz;
      p_wvx <= qw * vx; p_yvz <= qy * vz; p_zvy <= qz * vy;
      p_wvy <= qw * vy; p_xvz <= qx * vz; p_zvx <= qz * vx;
      p_wvz <= qw * vz; p_xvy <= qx * vy; p_yvx <= qy * vx;
      s1_w <= qw; s1_x <= qx; s1_y <= qy; s1_z <= qz;
    end
  end

  // Stage 2: sums forming t = q*(0,v) and the norm.
  always_ff @(posedge clk) begin
    if (en) begin
      tw <= -(TW'(p_xvx) + TW'(p_yvy) + TW'(p_zvz));
      tx <= TW'(p_wvx) + TW'(p_yvz) - TW'(p_zvy);
      ty <= TW'(p_wvy) - TW'(p_xvz) + TW'(p_zvx);
      tz <= TW'(p_wvz) + TW'(p_xvy) - TW'(p_yvx);
      n1 <= qvr_pkg::NormWidth'(p_ww) + qvr_pkg::NormWidth'(p_xx)
          + qvr_pkg::NormWidth'(p_yy) + qvr_pkg::NormWidth'(p_zz);
      s2_w <= s1_w; s2_x <= s1_x; s2_y <= s1_y; s2_z <= s1_z;
    end
  end

  // Stage 3: twelve products of t with conj(q).
  always_ff @(posedge clk) begin
    if (en) begin
      m[0]  <= NW'(tw * s2_x); m[1]  <= NW'(tx * s2_w);
      m[2]  <= NW'(ty * s2_z); m[3]  <= NW'(tz * s2_y);
      m[4]  <= NW'(tw * s2_y); m[5]  <= NW'(tx * s2_z);
      m[6]  <= NW'(ty * s2_w); m[7]  <= NW'(tz * s2_x);
      m[8]  <= NW'(tw * s2_z); m[9]  <= NW'(tx * s2_y);
      m[10] <= NW'(ty * s2_x); m[11] <= NW'(tz * s2_w);
      n2 <= n1;
    end
  end

  // Stage 4: sums of the vector part.
  always_ff @(posedge clk) begin
    if (en) begin
      nx <= m[1] - m[0] - m[2] + m[3];
      ny <= m[5] - m[4] + m[6] - m[7];
      nz <= m[10] - m[8] - m[9] + m[11];
      norm <= n2;
    end
  end
endmodule

>>> rtl/core/qvr_div.sv
// Pipelined restoring divider with rounding and saturation, one bit a stage.
`timescale 1ns / 1ps
module qvr_div (
  input  logic clk,
  input  logic en,
  input  logic signed [qvr_pkg::NumWidth-1:0]  num,
  input  logic        [qvr_pkg::NormWidth-1:0] den,
  output logic signed [qvr_pkg::OutWidth-1:0]  quo
);
  localparam int unsigned NW = qvr_pkg::NumWidth;
  localparam int unsigned DW = qvr_pkg::NormWidth + 1;
  localparam int unsigned QB = qvr_pkg::QuoBits;
  localparam int unsigned OW = qvr_pkg::OutWidth;
  localparam int unsigned RW = NW + 2;

  // Rounded magnitude is floor((2|N| + n) / 2n); divide a = 2|N|+n by d = 2n.
  logic [RW-1:0] rem  [QB+1];
  logic [DW-1:0] dv   [QB+1];
  logic [QB-1:0] q    [QB+1];
  logic          ovf  [QB+1];
  logic          neg  [QB+1];
  logic [NW-1:0] mag;
  logic [RW-1:0] a;

  always_comb begin
    mag = num[NW-1] ? NW'(-num) : NW'(num);
    a   = {mag, 1'b0} + RW'(den);
  end

  // Stage 0: quotient bits at and above QB only need a compare.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= a;
      dv[0]  <= {den, 1'b0};
      q[0]   <= '0;
      neg[0] <= num[NW-1];
      ovf[0] <= (a >> QB) >= RW'({den, 1'b0});
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_bit
    localparam int unsigned Sh = QB - 1 - i;
    logic [RW+QB-1:0] trial;
    logic             take;
    always_comb begin
      trial = (RW+QB)'(dv[i]) << Sh;
      take  = (RW+QB)'(rem[i]) >= trial;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? RW'((RW+QB)'(rem[i]) - trial) : rem[i];
        q[i+1]   <= q[i] | (QB'(take) << Sh);
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
        ovf[i+1] <= ovf[i];
      end
    end
  end

  logic [QB-1:0] bound;
  logic [QB-1:0] m;
  always_comb begin
    bound = neg[QB] ? QB'(1) << (OW - 1) : (QB'(1) << (OW - 1)) - QB'(1);
    m = (ovf[QB] || q[QB] > bound) ? bound : q[QB];
  end

  always_ff @(posedge clk) begin
    if (en) quo <= neg[QB] ? OW'(-m) : OW'(m);
  end
endmodule

>>> rtl/core/quaternion_vector_rotation.sv
// Top level: streaming quaternion rotation q*(0,v)*conj(q)/|q|^2.
// Pipeline: 4 product stages + 21 divider stages (entry compare, 19 quotient
// bits, sign and clamp) lie between the accepting edge and m_axis_tvalid.
// Throughput: one word per cycle; the pipeline advances whenever the last stage
// is empty or being taken, so a stall holds every stage in place.
// Reset clears only the valid bits; payload registers are left as they are.
`timescale 1ns / 1ps
`include "quaternion_vector_rotation_assert.svh"
module quaternion_vector_rotation (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z from bit 0 up
  input  logic [8*qvr_pkg::InBytes-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // rot_x, rot_y, rot_z from bit 0 up
  output logic [8*qvr_pkg::OutBytes-1:0] m_axis_tdata,
  // zero_norm
  output logic m_axis_tuser
);
  localparam int unsigned CW  = qvr_pkg::CompWidth;
  localparam int unsigned OW  = qvr_pkg::OutWidth;
  // Product stages, divider entry stage, one stage per quotient bit, clamp stage.
  // The 12 fraction bits cancel in N/n, so they never reach the arithmetic.
  localparam int unsigned Lat = 4 + qvr_pkg::QuoBits + 2;

  logic en;
  logic [Lat-1:0] vld;
  logic [Lat-1:0] zn;
  logic signed [CW-1:0] qw, qx, qy, qz, vx, vy, vz;
  logic signed [qvr_pkg::NormWidth-1:0] norm;
  logic signed [qvr_pkg::NumWidth-1:0]  nx, ny, nz;
  logic signed [OW-1:0] rx, ry, rz;

  // Advance whenever the last stage is empty or being taken.
  assign en = !vld[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;

  assign qw = s_axis_tdata[0*CW +: CW];
  assign qx = s_axis_tdata[1*CW +: CW];
  assign qy = s_axis_tdata[2*CW +: CW];
  assign qz = s_axis_tdata[3*CW +: CW];
  assign vx = s_axis_tdata[4*CW +: CW];
  assign vy = s_axis_tdata[5*CW +: CW];
  assign vz = s_axis_tdata[6*CW +: CW];

  qvr_mul u_mul (.clk, .en, .qw, .qx, .qy, .qz, .vx, .vy, .vz,
                 .norm, .nx, .ny, .nz);

  // A zero norm makes the divider saturate; the flag forces the result to 0.
  qvr_div u_dx (.clk, .en, .num(nx), .den(norm), .quo(rx));
  qvr_div u_dy (.clk, .en, .num(ny), .den(norm), .quo(ry));
  qvr_div u_dz (.clk, .en, .num(nz), .den(norm), .quo(rz));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid && s_axis_tready};
    end
  end

  always_ff @(posedge clk) begin
    if (en) zn <= {zn[Lat-2:0], (qw == '0) && (qx == '0) && (qy == '0) && (qz == '0)};
  end

  assign m_axis_tvalid = vld[Lat-1];
  assign m_axis_tuser  = zn[Lat-1];
  always_comb begin
    m_axis_tdata = '0;
    if (!zn[Lat-1]) m_axis_tdata[3*OW-1:0] = {rz, ry, rx};
  end

  `QVR_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `QVR_ASSERT_IMP(a_rdy, clk, rst, !m_axis_tvalid, s_axis_tready)
  `QVR_ASSERT_IMP(a_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
endmodule
